/* hdl/cpc_pkg.sv */
// Package for the circular prime checker.
// Holds widths, the radix constant and the controller/datapath command and status structs.
// No dependencies.
package cpc_pkg;

    localparam int WIDTH = 20;
    localparam int RADIX = 10;

    function automatic int calc_digits(input int w);
        logic [63:0] v;
        int          c;
        v = (64'd1 << w) - 64'd1;
        c = 0;
        while (v != 64'd0)
        begin
            c++;
            v = v / 64'd10;
        end
        return c;
    endfunction

    function automatic int calc_val_w(input int d);
        logic [63:0] p;
        int          i;
        p = 64'd1;
        for (i = 0; i < d; i++)
        begin
            p = p * 64'd10;
        end
        return $clog2(p);
    endfunction

    localparam int MAX_DIGITS  = calc_digits(WIDTH);
    localparam int VAL_W       = calc_val_w(MAX_DIGITS);
    localparam int SQ_W        = VAL_W + 1;
    localparam int F_W         = VAL_W / 2 + 2;
    localparam int DIG_W       = $clog2(MAX_DIGITS + 1);
    localparam int CNT_W       = $clog2(VAL_W);
    localparam int IN_TDATA_W  = ((WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    // v / 10 = (v * RECIP_10) >> RECIP_SH for every VAL_W-bit v
    localparam int          RECIP_SH = VAL_W + 4;
    localparam logic [63:0] RECIP_10 = ((64'd1 << RECIP_SH) + 64'd9) / 64'd10;

    typedef struct packed {
        logic load;
        logic dig_step;
        logic trial_init;
        logic trial_step;
        logic div_trial;
        logic div_rot;
        logic rot_apply;
        logic mark_pass;
        logic mark_fail;
        logic out_write;
    } cmd_t;

    typedef struct packed {
        logic more_digits;
        logic lt2;
        logic lt4;
        logic even;
        logic sq_gt;
        logic div_done;
        logic rot_ready;
        logic rem_zero;
        logic first;
        logic rot_last;
        logic out_free;
    } status_t;

endpackage

/* hdl/cpc_div.sv */
// Restoring divider, one quotient bit per cycle while busy.
// Gives the remainder. Depends on cpc_pkg.
module cpc_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [cpc_pkg::VAL_W-1:0] dividend,
    input  logic [cpc_pkg::VAL_W-1:0] divisor,
    output logic                    busy,
    output logic                    done,
    output logic [cpc_pkg::VAL_W-1:0] remainder
);

    localparam int VW = cpc_pkg::VAL_W;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [cpc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VW-1:0]               quo_reg, quo_next;
    logic [VW-1:0]               rem_reg, rem_next;
    logic [VW-1:0]               div_reg, div_next;
    logic [VW:0]                 shifted;
    logic [VW:0]                 diff;
    logic                        fits;

    assign shifted = {rem_reg, quo_reg[VW-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VW-2:0], fits};
            rem_next = fits ? diff[VW-1:0] : shifted[VW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == cpc_pkg::CNT_W'(VW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/cpc_datapath.sv */
// Datapath: current value, digit scale, trial divisor and its square, result register.
// Depends on cpc_pkg and cpc_div.
module cpc_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cpc_pkg::cmd_t           cmd,
    output cpc_pkg::status_t        status,
    input  logic [cpc_pkg::WIDTH-1:0] candidate,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    is_circular,
    output logic                    is_prime
);

    localparam int VW = cpc_pkg::VAL_W;
    localparam int DW = cpc_pkg::DIG_W;
    localparam int MW = 2 * VW + 4;

    logic [VW-1:0]            cur_reg, cur_next;
    logic [VW-1:0]            scale_reg, scale_next;
    logic [DW-1:0]            dig_reg, dig_next;
    logic [DW-1:0]            rot_cnt_reg, rot_cnt_next;
    logic [cpc_pkg::F_W-1:0]  f_reg, f_next;
    logic [cpc_pkg::SQ_W-1:0] sq_reg, sq_next;
    logic                     self_reg, self_next;
    logic                     circ_reg, circ_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_circ_reg, out_circ_next;
    logic                     out_prime_reg, out_prime_next;
    logic [VW-1:0]            rot_q_reg, rot_q_next;
    logic [3:0]               rot_r_reg, rot_r_next;
    logic [1:0]               rot_ph_reg, rot_ph_next;

    logic [VW+3:0]            scale_x10;
    logic [MW-1:0]            rot_mul;
    logic [3:0]               ten_q_lo;
    logic [VW+3:0]            rot_prod;
    logic [VW-1:0]            rot_val;
    logic [VW-1:0]            div_divisor;
    logic                     div_busy;
    logic                     div_done;
    logic [VW-1:0]            div_rem;

    assign div_divisor = VW'(f_reg);

    cpc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_trial),
        .dividend  (cur_reg),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign scale_x10 = ((VW + 4)'(scale_reg) << 3) + ((VW + 4)'(scale_reg) << 1);

    // divide by ten: reciprocal multiply, then low nibble of v - 10q
    assign rot_mul   = MW'(cur_reg) * MW'(cpc_pkg::RECIP_10[VW:0]);
    assign ten_q_lo  = {rot_q_reg[0], 3'b000} + {rot_q_reg[2:0], 1'b0};
    assign rot_prod  = (VW + 4)'(rot_r_reg) * (VW + 4)'(scale_reg);
    assign rot_val   = VW'(rot_prod + (VW + 4)'(rot_q_reg));

    always_comb
    begin
        status.more_digits = (scale_x10 <= (VW + 4)'(cur_reg))
                           && (dig_reg < DW'(cpc_pkg::MAX_DIGITS));
        status.lt2         = cur_reg < VW'(2);
        status.lt4         = cur_reg < VW'(4);
        status.even        = !cur_reg[0];
        status.sq_gt       = sq_reg > cpc_pkg::SQ_W'(cur_reg);
        status.div_done    = div_done;
        status.rot_ready   = rot_ph_reg[1];
        status.rem_zero    = div_rem == '0;
        status.first       = rot_cnt_reg == '0;
        status.rot_last    = rot_cnt_reg == dig_reg - DW'(1);
        status.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        cur_next       = cur_reg;
        scale_next     = scale_reg;
        dig_next       = dig_reg;
        rot_cnt_next   = rot_cnt_reg;
        f_next         = f_reg;
        sq_next        = sq_reg;
        self_next      = self_reg;
        circ_next      = circ_reg;
        out_circ_next  = out_circ_reg;
        out_prime_next = out_prime_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rot_q_next     = rot_q_reg;
        rot_r_next     = rot_r_reg;
        rot_ph_next    = {rot_ph_reg[0], cmd.div_rot};
        if (cmd.load)
        begin
            cur_next     = VW'(candidate);
            scale_next   = VW'(1);
            dig_next     = DW'(1);
            rot_cnt_next = '0;
        end
        if (cmd.dig_step)
        begin
            scale_next = VW'(scale_x10);
            dig_next   = dig_reg + DW'(1);
        end
        if (cmd.trial_init)
        begin
            f_next  = cpc_pkg::F_W'(3);
            sq_next = cpc_pkg::SQ_W'(9);
        end
        if (cmd.trial_step)
        begin
            // (f+2)^2 = f^2 + 4f + 4
            f_next  = f_reg + cpc_pkg::F_W'(2);
            sq_next = sq_reg + (cpc_pkg::SQ_W'(f_reg) << 2) + cpc_pkg::SQ_W'(4);
        end
        if (cmd.div_rot)
        begin
            rot_q_next = rot_mul[cpc_pkg::RECIP_SH +: VW];
        end
        if (rot_ph_reg[0])
        begin
            rot_r_next = cur_reg[3:0] - ten_q_lo;
        end
        if (cmd.rot_apply)
        begin
            cur_next     = rot_val;
            rot_cnt_next = rot_cnt_reg + DW'(1);
        end
        if (cmd.mark_pass)
        begin
            circ_next = 1'b1;
            if (status.first)
            begin
                self_next = 1'b1;
            end
        end
        if (cmd.mark_fail)
        begin
            circ_next = 1'b0;
            if (status.first)
            begin
                self_next = 1'b0;
            end
        end
        if (cmd.out_write)
        begin
            out_valid_next = 1'b1;
            out_circ_next  = circ_reg;
            out_prime_next = self_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            dig_reg       <= DW'(1);
            rot_cnt_reg   <= '0;
            rot_ph_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            dig_reg       <= dig_next;
            rot_cnt_reg   <= rot_cnt_next;
            rot_ph_reg    <= rot_ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        scale_reg     <= scale_next;
        f_reg         <= f_next;
        sq_reg        <= sq_next;
        self_reg      <= self_next;
        circ_reg      <= circ_next;
        out_circ_reg  <= out_circ_next;
        out_prime_reg <= out_prime_next;
        rot_q_reg     <= rot_q_next;
        rot_r_reg     <= rot_r_next;
    end

    assign out_valid   = out_valid_reg;
    assign is_circular = out_circ_reg;
    assign is_prime    = out_prime_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_write |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    a_circ_implies_prime: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_circ_reg || out_prime_reg))
        else $error("circular result on non-prime");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_trial |-> !div_busy)
        else $error("divider restarted while busy");

    a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rot_cnt_reg < dig_reg)
        else $error("rotation count past digit count");

endmodule

/* hdl/cpc_ctrl.sv */
// Controller FSM: digit count, trial division loop, rotations, result write.
// Depends on cpc_pkg.
module cpc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             idle,
    input  cpc_pkg::status_t status,
    output cpc_pkg::cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DIGITS = 9'b000000010,
        S_PCHK   = 9'b000000100,
        S_TCHK   = 9'b000001000,
        S_TWAIT  = 9'b000010000,
        S_PASS   = 9'b000100000,
        S_FAIL   = 9'b001000000,
        S_RWAIT  = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIGITS;
                end
            end
            S_DIGITS:
            begin
                if (status.more_digits)
                begin
                    cmd.dig_step = 1'b1;
                end
                else
                begin
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                priority if (status.lt2)
                begin
                    state_next = S_FAIL;
                end
                else if (status.lt4)
                begin
                    state_next = S_PASS;
                end
                else if (status.even)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    cmd.trial_init = 1'b1;
                    state_next     = S_TCHK;
                end
            end
            S_TCHK:
            begin
                if (status.sq_gt)
                begin
                    state_next = S_PASS;
                end
                else
                begin
                    cmd.div_trial = 1'b1;
                    state_next    = S_TWAIT;
                end
            end
            S_TWAIT:
            begin
                if (status.div_done)
                begin
                    if (status.rem_zero)
                    begin
                        state_next = S_FAIL;
                    end
                    else
                    begin
                        cmd.trial_step = 1'b1;
                        state_next     = S_TCHK;
                    end
                end
            end
            S_PASS:
            begin
                cmd.mark_pass = 1'b1;
                if (status.rot_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_rot = 1'b1;
                    state_next  = S_RWAIT;
                end
            end
            S_FAIL:
            begin
                cmd.mark_fail = 1'b1;
                state_next    = S_DONE;
            end
            S_RWAIT:
            begin
                if (status.rot_ready)
                begin
                    cmd.rot_apply = 1'b1;
                    state_next    = S_PCHK;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign idle = state_reg == S_IDLE;

    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !idle)
        else $error("controller idle right after load");

    a_wait_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TCHK && !status.sq_gt) |=> state_reg == S_TWAIT)
        else $error("trial division not started");

    a_done_leave: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status.out_free) |-> cmd.out_write)
        else $error("free result slot not written");

endmodule

/* hdl/circular_prime_checker.sv */
// Circular prime checker, top level. Steps: load and digit count, then for each tested value
// the range checks and about (sqrt(v)/2) trial divisions on the bit-serial divider; then a
// rotation to the next value, and at last the result write.
// One item at a time; the next transfer is taken once the result sits in the output register.
// rst_n asynchronously clears controller, counters and output valid.
module circular_prime_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // candidate
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // is_circular, is_prime
);

    cpc_pkg::cmd_t    cmd;
    cpc_pkg::status_t status;
    logic             idle;
    logic             is_circular;
    logic             is_prime;

    cpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .idle     (idle),
        .status   (status),
        .cmd      (cmd)
    );

    cpc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .candidate   (s_axis_tdata[cpc_pkg::WIDTH-1:0]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .is_circular (is_circular),
        .is_prime    (is_prime)
    );

    assign s_axis_tready = idle;
    assign m_axis_tdata  = {(cpc_pkg::OUT_TDATA_W - 2)'(0), is_prime, is_circular};

endmodule
